>>> rtl/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg
// Types and constants shared by the downmix decimator and its serial divider.
// ----------------------------------------------------------------------------
package cdd_pkg;

  // Fixed field layout of a frame and of the configuration registers.
  localparam int unsigned ChanFields  = 8;
  localparam int unsigned MapRegs     = 4;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned ChanIdxW    = $clog2(ChanFields);
  localparam int unsigned MapIdxW     = $clog2(MapRegs);

  // Clamp limits on the channel count and the number of map entries in use.
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned MapEntries  = 4;

  // Sum of up to ChanFields samples and its magnitude, and the sample count.
  localparam int unsigned SumW        = SampleW + $clog2(ChanFields);
  localparam int unsigned CntW        = $clog2(ChanFields + 1);
  localparam int unsigned DivCntW     = $clog2(SumW + 1);

  // Configuration register widths and indexes.
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned InChanW     = 4;
  localparam int unsigned DecW        = 8;
  localparam int unsigned MapCntW     = 3;
  localparam int unsigned MapEntW     = 5;

  localparam logic [CfgIdxW-1:0] RegInChannels = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDecimation = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMapCount   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMapEntry0  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMapEntry1  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMapEntry2  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMapEntry3  = 3'd6;

  typedef enum logic [2:0] {
    StIdle,
    StMap,
    StAll,
    StDivGo,
    StDiv,
    StOut
  } state_e;

  typedef struct packed {
    logic                start;
    logic [SumW-1:0]     dividend;
    logic [CntW-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SumW-1:0]     quotient;
  } div_rsp_t;

endpackage

>>> rtl/cdd_div.sv
// ----------------------------------------------------------------------------
// cdd_div
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cdd_div
  import cdd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SumW-1:0]    dvd_q, dvd_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]    dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW:0]      rem_shift;
  logic [CntW:0]      rem_sub;
  logic               q_bit;

  always_comb begin
    rem_shift = {rem_q, dvd_q[SumW-1]};
    rem_sub   = rem_shift - {1'b0, dvs_q};
    q_bit     = (rem_shift >= {1'b0, dvs_q});

    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = DivCntW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits back in CntW bits.
      rem_d = q_bit ? rem_sub[CntW-1:0] : rem_shift[CntW-1:0];
      dvd_d = {dvd_q[SumW-2:0], q_bit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

>>> rtl/channel_downmix_decimator_top.sv
// ----------------------------------------------------------------------------
// channel_downmix_decimator_top
// Decimates a multichannel frame stream and mixes each kept frame to mono.
// ----------------------------------------------------------------------------
// One input beat is one frame; tuser carries the buffer start flag, which
// restarts the decimation phase so that frame is always kept. A dropped frame
// leaves the input ready. A kept frame is summed one channel per cycle through
// a single adder, over the valid map entries in use or, when no entry is
// valid, over all channels, then divided by the number of samples added in a
// bit-serial divider (19 quotient steps), and the next frame can be accepted
// from the same cycle in which its mono beat is offered. The input is not ready
// while a kept frame is being worked on; a finished mono beat waits in the
// output register while the next frame is accepted.
module channel_downmix_decimator_top
  import cdd_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_idx_i,
  input  logic [CfgDataW-1:0]           cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // chan_0 .. chan_7, 16 bits each, chan_0 in the lowest bits
  input  logic [ChanFields*SampleW-1:0] s_axis_tdata_i,
  // buffer_start
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // mono_sample
  output logic [SampleW-1:0]            m_axis_tdata_o
);

  // Configuration registers.
  logic        [InChanW-1:0] in_chan_q;
  logic        [DecW-1:0]    dec_q;
  logic        [MapCntW-1:0] map_cnt_q;
  logic signed [MapEntW-1:0] map_q [MapRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_chan_q <= InChanW'(1);
      dec_q     <= DecW'(1);
      map_cnt_q <= '0;
      for (int i = 0; i < MapRegs; i++) begin
        map_q[i] <= '1;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegInChannels: in_chan_q <= cfg_data_i[InChanW-1:0];
        RegDecimation: dec_q     <= cfg_data_i[DecW-1:0];
        RegMapCount:   map_cnt_q <= cfg_data_i[MapCntW-1:0];
        RegMapEntry0:  map_q[0]  <= cfg_data_i[MapEntW-1:0];
        RegMapEntry1:  map_q[1]  <= cfg_data_i[MapEntW-1:0];
        RegMapEntry2:  map_q[2]  <= cfg_data_i[MapEntW-1:0];
        RegMapEntry3:  map_q[3]  <= cfg_data_i[MapEntW-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings after clamping.
  logic [CntW-1:0]    nch;
  logic [CntW-1:0]    nmap;
  logic [DecW-1:0]    dec_eff;

  always_comb begin
    if (in_chan_q == '0) begin
      nch = CntW'(1);
    end else if (32'(in_chan_q) > MaxChannels) begin
      nch = CntW'(MaxChannels);
    end else begin
      nch = CntW'(in_chan_q);
    end
    if (32'(map_cnt_q) > MapEntries) begin
      nmap = CntW'(MapEntries);
    end else begin
      nmap = CntW'(map_cnt_q);
    end
    dec_eff = (dec_q == '0) ? DecW'(1) : dec_q;
  end

  // Sequencer state and datapath registers.
  state_e                    state_q, state_d;
  logic        [DecW-1:0]    phase_q, phase_d;
  logic        [SampleW-1:0] samp_q [ChanFields];
  logic signed [SumW-1:0]    acc_q, acc_d;
  logic        [CntW-1:0]    cnt_q, cnt_d;
  logic        [CntW-1:0]    k_q, k_d;
  logic        [SampleW-1:0] res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  logic        [SampleW-1:0] out_data_q, out_data_d;

  logic                      in_fire;
  logic        [DecW-1:0]    phase_cur;
  logic        [DecW-1:0]    phase_inc;
  logic                      keep;
  logic signed [MapEntW-1:0] entry;
  logic                      entry_ok;
  logic        [ChanIdxW-1:0] sel_idx;
  logic signed [SumW-1:0]    add_sum;
  logic        [SumW-1:0]    sum_mag;
  logic        [SampleW-1:0] quo;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign phase_cur = s_axis_tuser_i ? '0 : phase_q;
  assign keep      = (phase_cur == '0);
  assign phase_inc = phase_cur + 1'b1;

  assign entry    = map_q[k_q[MapIdxW-1:0]];
  assign entry_ok = !entry[MapEntW-1] && (CntW'(entry[MapEntW-2:0]) < nch);

  // The shared adder takes a map-selected channel or walks all channels.
  assign sel_idx = (state_q == StMap) ? entry[ChanIdxW-1:0] : k_q[ChanIdxW-1:0];
  assign add_sum = acc_q + SumW'(signed'(samp_q[sel_idx]));

  assign sum_mag = acc_q[SumW-1] ? SumW'(-acc_q) : SumW'(acc_q);
  assign quo     = div_rsp.quotient[SampleW-1:0];

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    div_req.start    = 1'b0;
    div_req.dividend = sum_mag;
    div_req.divisor  = cnt_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          phase_d = (phase_inc >= dec_eff) ? '0 : phase_inc;
          acc_d   = '0;
          cnt_d   = '0;
          k_d     = '0;
          if (keep) begin
            state_d = StMap;
          end
        end
      end
      StMap: begin
        if (k_q == nmap) begin
          k_d = '0;
          if (cnt_q == '0) begin
            state_d = StAll;
          end else begin
            state_d = StDivGo;
          end
        end else begin
          if (entry_ok) begin
            acc_d = add_sum;
            cnt_d = cnt_q + 1'b1;
          end
          k_d = k_q + 1'b1;
        end
      end
      StAll: begin
        if (k_q == nch) begin
          cnt_d   = nch;
          state_d = StDivGo;
        end else begin
          acc_d = add_sum;
          k_d   = k_q + 1'b1;
        end
      end
      StDivGo: begin
        div_req.start = 1'b1;
        state_d       = StDiv;
      end
      StDiv: begin
        if (div_rsp.done) begin
          // Dividing the magnitude and restoring the sign truncates toward zero.
          res_d   = acc_q[SumW-1] ? SampleW'(-quo) : quo;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
    if (in_fire && keep) begin
      for (int i = 0; i < ChanFields; i++) begin
        samp_q[i] <= s_axis_tdata_i[i*SampleW +: SampleW];
      end
    end
  end

  cdd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
